### hw/rtl/aeac_pkg.sv
// Shared types and constants for the array element address cache.
package aeac_pkg;

	localparam int unsigned BASE_W   = 48;
	localparam int unsigned INDEX_W  = 31;
	localparam int unsigned ADDR_W   = 48;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned SHIFT_W  = 2;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned CFG_W    = 12;

	typedef enum logic [0:0] {
		CFG_ELEM_SIZE_LOG2 = 1'b0,
		CFG_PAYLOAD_OFFSET = 1'b1
	} cfg_reg_t;

	localparam logic [SHIFT_W-1:0]  ELEM_SIZE_LOG2_RST = 2'd2;
	localparam logic [OFFSET_W-1:0] PAYLOAD_OFFSET_RST = '0;

	typedef struct packed {
		logic               valid;
		logic [BASE_W-1:0]  base;
		logic [INDEX_W-1:0] index;
		logic [ADDR_W-1:0]  addr;
	} aeac_entry_t;

endpackage

### hw/rtl/aeac_store.sv
// Slot memory with post-reset clearing pass and write-to-read forwarding.
module aeac_store import aeac_pkg::*; #(
	parameter int unsigned CACHE_ENTRIES = 8192,
	parameter int unsigned SLOT_W        = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_slot,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  aeac_entry_t       wr_entry,
	output aeac_entry_t       rd_entry,
	output logic              busy
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_ENTRIES - 1);

	aeac_entry_t       mem [CACHE_ENTRIES];
	aeac_entry_t       mem_rd_q;
	aeac_entry_t       fwd_entry_q;
	logic              fwd_q;
	logic              clr_q;
	logic [SLOT_W-1:0] clr_idx_q;

	logic              we;
	logic [SLOT_W-1:0] wa;
	aeac_entry_t       wd;

	assign we = clr_q | wr_en;
	assign wa = clr_q ? clr_idx_q : wr_slot;
	assign wd = clr_q ? '0 : wr_entry;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			mem_rd_q    <= mem[rd_slot];
			fwd_entry_q <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			fwd_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				if (clr_idx_q == LAST_SLOT) begin
					clr_q <= 1'b0;
				end
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (rd_en) begin
				fwd_q <= wr_en && (wr_slot == rd_slot);
			end
		end
	end

	assign rd_entry = fwd_q ? fwd_entry_q : mem_rd_q;
	assign busy     = clr_q;

	a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !rd_en && !wr_en)
		else $error("slot access during clearing pass");

	a_clear_covers_all: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_idx_q) == LAST_SLOT)
		else $error("clearing pass ended early");

	a_clear_restarts_never: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_q |=> !clr_q)
		else $error("clearing pass restarted without reset");

endmodule

### hw/rtl/array_element_address_cache_unit.sv
// Array element address cache: direct-mapped lookup of element byte addresses.
//
// Requests arrive on in_valid/in_ready carrying array_base and element_index.
// Each request yields exactly one result on out_valid/out_ready: the element
// byte address, a hit flag and the saturating hit and miss totals that
// include this request. Results leave in request order.
// An accepted request waits in the read stage for the synchronous slot
// memory read; compare, address add and fill then load the output register.
// Throughput is one request per cycle when the output is not stalled and no
// clearing pass runs; the slot memory read-modify-write is the only
// recurrence, covered by forwarding from the fill write. After reset the
// block runs a clearing pass over the slot memory; in_ready stays low until
// it completes. Configuration writes (cfg_we/cfg_index/cfg_data) are taken at
// any time. When the receiver stalls, the result holds in the output register,
// one more request can wait in the read stage, and then in_ready drops.
module array_element_address_cache_unit import aeac_pkg::*; #(
	parameter int unsigned CACHE_ENTRIES = 8192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  cfg_reg_t            cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BASE_W-1:0]   array_base,
	input  logic [INDEX_W-1:0]  element_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ADDR_W-1:0]   element_address,
	output logic                was_hit,
	output logic [COUNT_W-1:0]  hit_total,
	output logic [COUNT_W-1:0]  miss_total
);

	localparam int unsigned       SLOT_W    = $clog2(CACHE_ENTRIES);
	localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(CACHE_ENTRIES - 1);

	logic [SHIFT_W-1:0]  esl_q;
	logic [OFFSET_W-1:0] off_q;

	logic                v_s1;
	logic [BASE_W-1:0]   base_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic [SLOT_W-1:0]   slot_s1;

	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic                out_hit_q;
	logic [COUNT_W-1:0]  hit_cnt_q;
	logic [COUNT_W-1:0]  miss_cnt_q;

	logic                busy;
	logic                accept;
	logic                adv;
	logic [SLOT_W-1:0]   in_slot;
	aeac_entry_t         rd_entry;
	aeac_entry_t         wr_entry;
	logic                hit;
	logic                wr_en;
	logic [ADDR_W-1:0]   calc_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esl_q <= ELEM_SIZE_LOG2_RST;
			off_q <= PAYLOAD_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ELEM_SIZE_LOG2: esl_q <= cfg_data[SHIFT_W-1:0];
				CFG_PAYLOAD_OFFSET: off_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_slot  = (array_base[SLOT_W-1:0] ^ element_index[SLOT_W-1:0]) & SLOT_MASK;
	assign adv      = v_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~busy & (~v_s1 | adv);
	assign accept   = in_valid & in_ready;

	assign hit = rd_entry.valid && (rd_entry.base == base_s1) && (rd_entry.index == idx_s1);
	assign calc_addr = base_s1 + ADDR_W'(off_q) + (ADDR_W'(idx_s1) << esl_q);
	assign wr_en = adv & ~hit;
	assign wr_entry = '{valid: 1'b1, base: base_s1, index: idx_s1, addr: calc_addr};

	aeac_store #(
		.CACHE_ENTRIES (CACHE_ENTRIES),
		.SLOT_W        (SLOT_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_slot  (in_slot),
		.wr_en    (wr_en),
		.wr_slot  (slot_s1),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry),
		.busy     (busy)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1 <= array_base;
			idx_s1  <= element_index;
			slot_s1 <= in_slot;
		end
		if (adv) begin
			out_addr_q <= hit ? rd_entry.addr : calc_addr;
			out_hit_q  <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && hit && (hit_cnt_q != '1)) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (adv && !hit && (miss_cnt_q != '1)) begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign element_address = out_addr_q;
	assign was_hit         = out_hit_q;
	assign hit_total       = hit_cnt_q;
	assign miss_total      = miss_cnt_q;

	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_hit_q |-> hit_cnt_q != '0)
		else $error("hit reported with zero hit total");

	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_hit_q |-> miss_cnt_q != '0)
		else $error("miss reported with zero miss total");

	a_counts_move_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(hit_cnt_q) && $stable(miss_cnt_q))
		else $error("counter changed without a result");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !accept && !v_s1)
		else $error("request accepted during clearing pass");

endmodule

### tb/sv/tb_array_element_address_cache_unit.sv
// Self-checking testbench for the array element address cache unit.
module tb_array_element_address_cache_unit;
	import aeac_pkg::*;

	localparam int unsigned CACHE_ENTRIES = 8192;
	localparam int unsigned SLOT_W        = $clog2(CACHE_ENTRIES);
	localparam int unsigned PHASE_ITEMS   = 230;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	typedef struct {
		logic [BASE_W-1:0]  base;
		logic [INDEX_W-1:0] index;
		bit                 wait_drain;
	} pending_request_t;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic               hit;
		logic [COUNT_W-1:0] hit_total;
		logic [COUNT_W-1:0] miss_total;
	} lookup_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	cfg_reg_t           cfg_index = CFG_ELEM_SIZE_LOG2;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [BASE_W-1:0]  array_base = '0;
	logic [INDEX_W-1:0] element_index = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ADDR_W-1:0]  element_address;
	logic               was_hit;
	logic [COUNT_W-1:0] hit_total;
	logic [COUNT_W-1:0] miss_total;

	array_element_address_cache_unit #(.CACHE_ENTRIES(CACHE_ENTRIES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.array_base(array_base),
		.element_index(element_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.element_address(element_address),
		.was_hit(was_hit),
		.hit_total(hit_total),
		.miss_total(miss_total)
	);

	// Shadow copy of the slot table and registers
	bit                 fill_valid [CACHE_ENTRIES];
	logic [BASE_W-1:0]  fill_base  [CACHE_ENTRIES];
	logic [INDEX_W-1:0] fill_index [CACHE_ENTRIES];
	logic [ADDR_W-1:0]  fill_addr  [CACHE_ENTRIES];
	logic [COUNT_W-1:0] hits_so_far = '0;
	logic [COUNT_W-1:0] misses_so_far = '0;
	logic [SHIFT_W-1:0]  size_shift = ELEM_SIZE_LOG2_RST;
	logic [OFFSET_W-1:0] byte_offset = PAYLOAD_OFFSET_RST;

	pending_request_t pending_requests[$];
	pending_request_t recent_pairs[$];
	lookup_result_t   expected_results[$];
	bit             request_on_bus = 1'b0;
	int unsigned    sender_idle_pct = 20;
	int unsigned    receiver_stall_pct = 59;
	int unsigned    error_count = 0;
	int unsigned    requests_sent = 0;
	int unsigned    register_writes = 0;
	int unsigned    cycle_count = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic lookup_result_t predict_lookup(input logic [BASE_W-1:0] base,
							   input logic [INDEX_W-1:0] index);
		lookup_result_t r;
		logic [SLOT_W-1:0] slot;
		slot = base[SLOT_W-1:0] ^ index[SLOT_W-1:0];
		if (fill_valid[slot] && fill_base[slot] == base && fill_index[slot] == index) begin
			r.addr = fill_addr[slot];
			r.hit = 1'b1;
			if (hits_so_far != '1) hits_so_far = hits_so_far + 1'b1;
		end else begin
			r.addr = base + ADDR_W'(byte_offset) + (ADDR_W'(index) << size_shift);
			fill_valid[slot] = 1'b1;
			fill_base[slot] = base;
			fill_index[slot] = index;
			fill_addr[slot] = r.addr;
			r.hit = 1'b0;
			if (misses_so_far != '1) misses_so_far = misses_so_far + 1'b1;
		end
		r.hit_total = hits_so_far;
		r.miss_total = misses_so_far;
		return r;
	endfunction

	function automatic void queue_request(input logic [BASE_W-1:0] base,
					      input logic [INDEX_W-1:0] index);
		pending_request_t req;
		req.base = base;
		req.index = index;
		req.wait_drain = 1'b0;
		pending_requests.push_back(req);
	endfunction

	// Mostly repeats of recent pairs (hits) and same-slot aliases (evictions)
	function automatic pending_request_t make_request();
		pending_request_t req;
		pending_request_t seen;
		int unsigned pick;
		logic [SLOT_W-1:0] slot;
		pick = $urandom_range(99);
		req.wait_drain = ($urandom_range(99) == 0);
		req.base = BASE_W'({$urandom, $urandom});
		req.index = INDEX_W'($urandom);
		if (recent_pairs.size() != 0 && pick < 65) begin
			seen = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
			if (pick < 45) begin
				req.base = seen.base;
				req.index = seen.index;
			end else begin
				slot = seen.base[SLOT_W-1:0] ^ seen.index[SLOT_W-1:0];
				if (pick < 55) req.base = seen.base;
				req.index[SLOT_W-1:0] = req.base[SLOT_W-1:0] ^ slot;
			end
		end else if (pick >= 88) begin
			req.base = (pick % 2 == 0) ? BASE_W'($urandom_range(255))
						   : ~BASE_W'($urandom_range(255));
			req.index = (pick % 3 == 0) ? INDEX_W'($urandom_range(255))
						    : ~INDEX_W'($urandom_range(255));
		end
		recent_pairs.push_back(req);
		if (recent_pairs.size() > 48) void'(recent_pairs.pop_front());
		return req;
	endfunction

	task automatic write_register(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == CFG_ELEM_SIZE_LOG2) size_shift = value[SHIFT_W-1:0];
		else byte_offset = value[OFFSET_W-1:0];
		register_writes++;
	endtask

	// Upper bits of the size word are junk; only the low bits may count
	task automatic set_registers(input logic [SHIFT_W-1:0] shift,
				     input logic [OFFSET_W-1:0] offset);
		logic [CFG_W-1:0] size_word;
		size_word = CFG_W'($urandom);
		size_word[SHIFT_W-1:0] = shift;
		write_register(CFG_ELEM_SIZE_LOG2, size_word);
		write_register(CFG_PAYLOAD_OFFSET, CFG_W'(offset));
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || request_on_bus || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		pending_request_t upcoming;
		if (!arst_n) begin
			in_valid <= 1'b0;
			request_on_bus = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_lookup(array_base, element_index));
				requests_sent++;
				request_on_bus = 1'b0;
			end
			if (!request_on_bus) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
				    !(pending_requests[0].wait_drain && expected_results.size() != 0)) begin
					upcoming = pending_requests.pop_front();
					array_base <= upcoming.base;
					element_index <= upcoming.index;
					in_valid <= 1'b1;
					request_on_bus = 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: address %h", element_address);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (element_address !== want.addr) begin
						$error("element_address: expected %h, got %h", want.addr,
						       element_address);
						error_count++;
					end
					if (was_hit !== want.hit) begin
						$error("was_hit: expected %0b, got %0b", want.hit, was_hit);
						error_count++;
					end
					if (hit_total !== want.hit_total) begin
						$error("hit_total: expected %0d, got %0d", want.hit_total, hit_total);
						error_count++;
					end
					if (miss_total !== want.miss_total) begin
						$error("miss_total: expected %0d, got %0d", want.miss_total,
						       miss_total);
						error_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		pending_request_t req;
		logic [SHIFT_W-1:0]  shift_choice;
		logic [OFFSET_W-1:0] offset_choice;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values; zero pair must miss, then aliasing at slot 0 and 1
		queue_request('0, '0);
		queue_request('0, '0);
		queue_request('1, '1);
		queue_request('1, '1);
		queue_request('0, '0);
		queue_request(48'h1, 31'h0);
		queue_request(48'h0, 31'h1);
		queue_request(48'h1, 31'h0);
		queue_request(48'hAAAA_AAAA_AAAA, 31'h5555_5555);
		queue_request(48'h5555_5555_5555, 31'h2AAA_AAAA);
		queue_request(48'h5555_5555_5555, 31'h2AAA_AAAA);
		queue_request(48'h0000_0000_2000, 31'h4000_2000);
		wait_idle();

		// Stored addresses must survive a register change; new fills wrap
		set_registers(2'd3, 12'hFFF);
		queue_request(48'h5555_5555_5555, 31'h2AAA_AAAA);
		queue_request('1, '0);
		queue_request(48'hFFFF_FFFF_F000, '1);
		queue_request(48'hFFFF_FFFF_F000, '1);
		queue_request('0, '1);
		queue_request(48'hAAAA_AAAA_AAAA, 31'h5555_5555);
		wait_idle();

		set_registers(2'd0, 12'h000);
		queue_request('0, '0);
		queue_request(48'h1234_5678_9ABC, 31'h0ABC_DEF0);
		queue_request('1, '1);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					shift_choice = 2'd0;
					offset_choice = '0;
				end
				1: begin
					shift_choice = 2'd3;
					offset_choice = '1;
				end
				2: begin
					shift_choice = 2'd1;
					offset_choice = OFFSET_W'($urandom);
				end
				3: begin
					shift_choice = 2'd2;
					offset_choice = OFFSET_W'($urandom);
				end
				4: begin
					shift_choice = 2'd3;
					offset_choice = '0;
				end
				default: begin
					shift_choice = 2'd0;
					offset_choice = '1;
				end
			endcase
			if (phase < 2) begin
				sender_idle_pct = 20;
				receiver_stall_pct = 59;
			end else if (phase < 4) begin
				sender_idle_pct = 59;
				receiver_stall_pct = 20;
			end else begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			set_registers(shift_choice, offset_choice);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				req = make_request();
				if (n % 97 == 50) req.wait_drain = 1'b1;
				pending_requests.push_back(req);
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d lookups: %0d hits and %0d misses predicted, %0d register writes.",
			 requests_sent, hits_so_far, misses_so_far, register_writes);
		$display("Covered slot aliasing, address wrap, stale hits across register changes.");
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/aeac_pkg.sv
hw/rtl/aeac_store.sv
hw/rtl/array_element_address_cache_unit.sv
tb/sv/tb_array_element_address_cache_unit.sv
